>>> src/spq_pkg.sv
// Package with shared constants and controller/datapath types for the sorted priority queue.
`default_nettype none

package spq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int VALUE_BITS_DEF = 32;
	localparam int PRIO_BITS_DEF  = 8;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef struct packed {
		logic load_item;
		logic clr_result;
		logic ram_rd;
		logic ram_wr;
		logic wr_item;
		logic set_accepted;
		logic set_underflow;
		logic set_overflow;
		logic cap_pop;
		logic cap_head;
		logic head_nonempty;
	} spq_cmd_t;

	typedef struct packed {
		logic prio_gt;
	} spq_stat_t;

endpackage

`default_nettype wire

>>> src/spq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module spq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> src/spq_datapath.sv
// Datapath of the sorted priority queue: entry memory, item registers and result registers.
`default_nettype none

module spq_datapath
	import spq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int PRIO_BITS  = PRIO_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire spq_cmd_t                     ctl,
	output spq_stat_t                         stat,
	input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
	input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  wire logic signed [VALUE_BITS-1:0] item_value,
	input  wire logic [PRIO_BITS-1:0]         item_priority,
	output logic                              accepted,
	output logic                              underflow,
	output logic                              overflow,
	output logic signed [VALUE_BITS-1:0]      popped_value,
	output logic [PRIO_BITS-1:0]              popped_priority,
	output logic                              head_valid,
	output logic signed [VALUE_BITS-1:0]      head_value,
	output logic [PRIO_BITS-1:0]              head_priority
);

	localparam int EW = VALUE_BITS + PRIO_BITS;

	logic [VALUE_BITS-1:0] item_value_q;
	logic [PRIO_BITS-1:0]  item_prio_q;
	logic [EW-1:0]         wr_data;
	logic [EW-1:0]         rd_data;
	logic [VALUE_BITS-1:0] rd_value;
	logic [PRIO_BITS-1:0]  rd_prio;

	logic                  accepted_q;
	logic                  underflow_q;
	logic                  overflow_q;
	logic [VALUE_BITS-1:0] popped_value_q;
	logic [PRIO_BITS-1:0]  popped_prio_q;
	logic                  head_valid_q;
	logic [VALUE_BITS-1:0] head_value_q;
	logic [PRIO_BITS-1:0]  head_prio_q;

	assign rd_value = rd_data[EW-1:PRIO_BITS];
	assign rd_prio  = rd_data[PRIO_BITS-1:0];
	assign wr_data  = ctl.wr_item ? {item_value_q, item_prio_q} : rd_data;
	assign stat.prio_gt = rd_prio > item_prio_q;

	spq_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ctl.ram_wr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (ctl.ram_rd),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			item_value_q <= item_value;
			item_prio_q  <= item_priority;
		end
		if (ctl.clr_result) begin
			accepted_q     <= 1'b0;
			underflow_q    <= ctl.set_underflow;
			overflow_q     <= ctl.set_overflow;
			popped_value_q <= '0;
			popped_prio_q  <= '0;
		end else begin
			if (ctl.set_accepted) begin
				accepted_q <= 1'b1;
			end
			if (ctl.set_underflow) begin
				underflow_q <= 1'b1;
			end
			if (ctl.set_overflow) begin
				overflow_q <= 1'b1;
			end
			if (ctl.cap_pop) begin
				popped_value_q <= rd_value;
				popped_prio_q  <= rd_prio;
			end
		end
		if (ctl.cap_head) begin
			head_valid_q <= ctl.head_nonempty;
			head_value_q <= ctl.head_nonempty ? rd_value : '0;
			head_prio_q  <= ctl.head_nonempty ? rd_prio : '0;
		end
	end

	assign accepted        = accepted_q;
	assign underflow       = underflow_q;
	assign overflow        = overflow_q;
	assign popped_value    = popped_value_q;
	assign popped_priority = popped_prio_q;
	assign head_valid      = head_valid_q;
	assign head_value      = head_value_q;
	assign head_priority   = head_prio_q;

endmodule

`default_nettype wire

>>> src/spq_ctrl.sv
// Controller of the sorted priority queue: sequencer, slot index and occupancy counter.
`default_nettype none

module spq_ctrl
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic                       cmd,
	output logic                            busy,
	output logic                            done,
	output spq_cmd_t                        ctl,
	input  wire spq_stat_t                  stat,
	output logic [$clog2(DEPTH)-1:0]        rd_addr,
	output logic [$clog2(DEPTH)-1:0]        wr_addr,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_PUSH_RD  = 4'd1;
	localparam logic [3:0] S_PUSH_CMP = 4'd2;
	localparam logic [3:0] S_PUSH_INS = 4'd3;
	localparam logic [3:0] S_POP_RD   = 4'd4;
	localparam logic [3:0] S_POP_CAP  = 4'd5;
	localparam logic [3:0] S_MV_RD    = 4'd6;
	localparam logic [3:0] S_MV_WR    = 4'd7;
	localparam logic [3:0] S_HEAD_RD  = 4'd8;
	localparam logic [3:0] S_HEAD_CAP = 4'd9;
	localparam logic [3:0] S_RESP     = 4'd10;

	logic [3:0]    state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [CW-1:0] occ_q, occ_d;
	logic [CW-1:0] occ_m1;

	assign occ_m1 = occ_q - CW'(1);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		occ_d   = occ_q;
		ctl     = '0;
		rd_addr = idx_q;
		wr_addr = idx_q;
		done    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load_item  = 1'b1;
					ctl.clr_result = 1'b1;
					if (cmd == CMD_PUSH) begin
						if (occ_q == CW'(DEPTH)) begin
							ctl.set_overflow = 1'b1;
							state_d = S_HEAD_RD;
						end else if (occ_q == '0) begin
							idx_d   = '0;
							state_d = S_PUSH_INS;
						end else begin
							idx_d   = AW'(occ_m1);
							state_d = S_PUSH_RD;
						end
					end else begin
						if (occ_q == '0) begin
							ctl.set_underflow = 1'b1;
							state_d = S_HEAD_RD;
						end else begin
							state_d = S_POP_RD;
						end
					end
				end
			end
			S_PUSH_RD: begin
				ctl.ram_rd = 1'b1;
				state_d    = S_PUSH_CMP;
			end
			S_PUSH_CMP: begin
				ctl.ram_wr = 1'b1;
				wr_addr    = idx_q + AW'(1);
				if (stat.prio_gt) begin
					if (idx_q == '0) begin
						state_d = S_PUSH_INS;
					end else begin
						idx_d   = idx_q - AW'(1);
						state_d = S_PUSH_RD;
					end
				end else begin
					ctl.wr_item      = 1'b1;
					ctl.set_accepted = 1'b1;
					occ_d            = occ_q + CW'(1);
					state_d          = S_HEAD_RD;
				end
			end
			S_PUSH_INS: begin
				ctl.ram_wr       = 1'b1;
				ctl.wr_item      = 1'b1;
				ctl.set_accepted = 1'b1;
				occ_d            = occ_q + CW'(1);
				state_d          = S_HEAD_RD;
			end
			S_POP_RD: begin
				ctl.ram_rd = 1'b1;
				rd_addr    = '0;
				state_d    = S_POP_CAP;
			end
			S_POP_CAP: begin
				ctl.cap_pop      = 1'b1;
				ctl.set_accepted = 1'b1;
				if (occ_q == CW'(1)) begin
					occ_d   = occ_m1;
					state_d = S_HEAD_RD;
				end else begin
					idx_d   = AW'(1);
					state_d = S_MV_RD;
				end
			end
			S_MV_RD: begin
				ctl.ram_rd = 1'b1;
				state_d    = S_MV_WR;
			end
			S_MV_WR: begin
				ctl.ram_wr = 1'b1;
				wr_addr    = idx_q - AW'(1);
				if (CW'(idx_q) == occ_m1) begin
					occ_d   = occ_m1;
					state_d = S_HEAD_RD;
				end else begin
					idx_d   = idx_q + AW'(1);
					state_d = S_MV_RD;
				end
			end
			S_HEAD_RD: begin
				ctl.ram_rd = 1'b1;
				rd_addr    = '0;
				state_d    = S_HEAD_CAP;
			end
			S_HEAD_CAP: begin
				ctl.cap_head      = 1'b1;
				ctl.head_nonempty = occ_q != '0;
				state_d           = S_RESP;
			end
			S_RESP: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			occ_q   <= occ_d;
		end
	end

	assign busy  = state_q != S_IDLE;
	assign count = occ_q;

endmodule

`default_nettype wire

>>> src/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: controller and datapath joined by command and status.
//
// An item is a push (cmd low) of item_value with item_priority, or a pop (cmd high).
// It is accepted at a rising edge where start is high and busy is low; busy then stays
// high until the result has been shown. Each item gives one result, shown for exactly
// one cycle with done high; the receiver cannot stall it.
// Entries are kept sorted in a single memory, lowest priority number at slot 0, and
// equal priorities keep arrival order.
// A push moves entries one at a time from the tail, each by a memory read, then a
// compare and write. A pop reads the head and moves the remaining entries down one
// slot. Underflow and overflow move no entries. The next item can be accepted in the
// cycle after done. Reset empties the queue at once; the memory needs no clearing.
`default_nettype none

module sorted_priority_queue_unit
	import spq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int PRIO_BITS  = PRIO_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         cmd,
	input  wire logic signed [VALUE_BITS-1:0] item_value,
	input  wire logic [PRIO_BITS-1:0]         item_priority,
	output logic                              done,
	output logic                              accepted,
	output logic                              underflow,
	output logic                              overflow,
	output logic signed [VALUE_BITS-1:0]      popped_value,
	output logic [PRIO_BITS-1:0]              popped_priority,
	output logic                              head_valid,
	output logic signed [VALUE_BITS-1:0]      head_value,
	output logic [PRIO_BITS-1:0]              head_priority,
	output logic [$clog2(DEPTH+1)-1:0]        entry_count
);

	localparam int AW = $clog2(DEPTH);

	spq_cmd_t      ctl;
	spq_stat_t     stat;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	spq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.ctl     (ctl),
		.stat    (stat),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.count   (entry_count)
	);

	spq_datapath #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS),
		.PRIO_BITS  (PRIO_BITS)
	) u_datapath (
		.clk             (clk),
		.ctl             (ctl),
		.stat            (stat),
		.rd_addr         (rd_addr),
		.wr_addr         (wr_addr),
		.item_value      (item_value),
		.item_priority   (item_priority),
		.accepted        (accepted),
		.underflow       (underflow),
		.overflow        (overflow),
		.popped_value    (popped_value),
		.popped_priority (popped_priority),
		.head_valid      (head_valid),
		.head_value      (head_value),
		.head_priority   (head_priority)
	);

endmodule

`default_nettype wire

>>> sim/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority queue unit, with its own sorted-list queue predictor.
module sorted_priority_queue_unit_tb;
	import spq_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int VBITS        = VALUE_BITS_DEF;
	localparam int PBITS        = PRIO_BITS_DEF;
	localparam int CBITS        = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS = 1550;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 1000000;

	localparam int PRIO_FULL    = 0;
	localparam int PRIO_NARROW  = 1;
	localparam int PRIO_EXTREME = 2;

	typedef struct packed {
		logic             accepted;
		logic             underflow;
		logic             overflow;
		logic [VBITS-1:0] popped_value;
		logic [PBITS-1:0] popped_priority;
		logic             head_valid;
		logic [VBITS-1:0] head_value;
		logic [PBITS-1:0] head_priority;
		logic [CBITS-1:0] entry_count;
	} queue_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    cmd;
	logic signed [VBITS-1:0] item_value;
	logic [PBITS-1:0]        item_priority;
	logic                    done;
	logic                    accepted;
	logic                    underflow;
	logic                    overflow;
	logic signed [VBITS-1:0] popped_value;
	logic [PBITS-1:0]        popped_priority;
	logic                    head_valid;
	logic signed [VBITS-1:0] head_value;
	logic [PBITS-1:0]        head_priority;
	logic [CBITS-1:0]        entry_count;

	logic [VBITS-1:0] model_value [DEPTH];
	logic [PBITS-1:0] model_prio [DEPTH];
	int               model_count;
	queue_result_t    pending_outcomes [$];
	int               error_count;
	int               cycle_count;
	bit               idle_enable;

	sorted_priority_queue_unit #(
		.DEPTH(DEPTH),
		.VALUE_BITS(VBITS),
		.PRIO_BITS(PBITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.item_value(item_value),
		.item_priority(item_priority),
		.done(done),
		.accepted(accepted),
		.underflow(underflow),
		.overflow(overflow),
		.popped_value(popped_value),
		.popped_priority(popped_priority),
		.head_valid(head_valid),
		.head_value(head_value),
		.head_priority(head_priority),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic queue_result_t apply_queue_op(input logic op, input logic [VBITS-1:0] val,
			input logic [PBITS-1:0] pri);
		queue_result_t r;
		int pos;
		r = '0;
		if (op == CMD_PUSH) begin
			if (model_count >= DEPTH) begin
				r.overflow = 1'b1;
			end else begin
				pos = 0;
				while (pos < model_count && model_prio[pos] <= pri)
					pos++;
				for (int i = model_count; i > pos; i--) begin
					model_value[i] = model_value[i-1];
					model_prio[i] = model_prio[i-1];
				end
				model_value[pos] = val;
				model_prio[pos] = pri;
				model_count++;
				r.accepted = 1'b1;
			end
		end else begin
			if (model_count == 0) begin
				r.underflow = 1'b1;
			end else begin
				r.popped_value = model_value[0];
				r.popped_priority = model_prio[0];
				for (int i = 0; i + 1 < model_count; i++) begin
					model_value[i] = model_value[i+1];
					model_prio[i] = model_prio[i+1];
				end
				model_count--;
				r.accepted = 1'b1;
			end
		end
		if (model_count > 0) begin
			r.head_valid = 1'b1;
			r.head_value = model_value[0];
			r.head_priority = model_prio[0];
		end
		r.entry_count = model_count[CBITS-1:0];
		return r;
	endfunction

	function automatic logic [PBITS-1:0] draw_priority(input int mode);
		case (mode)
			PRIO_NARROW: begin
				return PBITS'($urandom_range(0, 3));
			end
			PRIO_EXTREME: begin
				return $urandom_range(0, 1) ? '1 : '0;
			end
			default: begin
				return PBITS'($urandom);
			end
		endcase
	endfunction

	task automatic send_item(input logic op, input logic [VBITS-1:0] val,
			input logic [PBITS-1:0] pri);
		int gap;
		gap = idle_enable ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		item_value <= val;
		item_priority <= pri;
		do @(posedge clk); while (busy);
		pending_outcomes.push_back(apply_queue_op(op, val, pri));
	endtask

	task automatic check_field(input string name, input logic [VBITS-1:0] want,
			input logic [VBITS-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual count %0d", $time,
					entry_count);
				error_count++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("accepted", want.accepted, accepted);
				check_field("underflow", want.underflow, underflow);
				check_field("overflow", want.overflow, overflow);
				check_field("popped_value", want.popped_value, popped_value);
				check_field("popped_priority", want.popped_priority, popped_priority);
				check_field("head_valid", want.head_valid, head_valid);
				check_field("head_value", want.head_value, head_value);
				check_field("head_priority", want.head_priority, head_priority);
				check_field("entry_count", want.entry_count, entry_count);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_priority_queue_unit_tb: done, errors");
			$finish;
		end
	end

	task automatic test_empty_pop();
		send_item(CMD_POP, '1, '1);
	endtask

	task automatic test_field_extremes();
		send_item(CMD_PUSH, {1'b1, {(VBITS-1){1'b0}}}, '1);
		send_item(CMD_PUSH, {1'b0, {(VBITS-1){1'b1}}}, '0);
		send_item(CMD_PUSH, '0, '0);
		send_item(CMD_PUSH, '1, PBITS'(128));
		repeat (5) send_item(CMD_POP, VBITS'($urandom), PBITS'($urandom));
	endtask

	task automatic test_tie_order();
		send_item(CMD_PUSH, VBITS'(1), PBITS'(5));
		send_item(CMD_PUSH, VBITS'(2), PBITS'(5));
		send_item(CMD_PUSH, VBITS'(3), PBITS'(4));
		send_item(CMD_PUSH, VBITS'(4), PBITS'(5));
		repeat (4) send_item(CMD_POP, '0, '0);
	endtask

	task automatic test_full_queue();
		repeat (DEPTH) send_item(CMD_PUSH, VBITS'($urandom), draw_priority(PRIO_NARROW));
		send_item(CMD_PUSH, VBITS'($urandom), '0);
		send_item(CMD_PUSH, VBITS'($urandom), '1);
		send_item(CMD_POP, VBITS'($urandom), PBITS'($urandom));
		send_item(CMD_PUSH, VBITS'($urandom), draw_priority(PRIO_FULL));
		repeat (DEPTH + 1) send_item(CMD_POP, VBITS'($urandom), PBITS'($urandom));
	endtask

	task automatic test_random_traffic();
		int sent;
		int burst;
		int push_pct;
		int prio_mode;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(10, 50);
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 50;
				default: push_pct = 15;
			endcase
			prio_mode = $urandom_range(PRIO_FULL, PRIO_EXTREME);
			idle_enable = ($urandom_range(0, 3) != 0);
			repeat (burst) begin
				if ($urandom_range(0, 99) < push_pct)
					send_item(CMD_PUSH, VBITS'($urandom), draw_priority(prio_mode));
				else
					send_item(CMD_POP, VBITS'($urandom), PBITS'($urandom));
				sent++;
			end
		end
		idle_enable = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_PUSH;
		item_value <= '0;
		item_priority <= '0;
		model_count = 0;
		idle_enable = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pop();
		test_field_extremes();
		test_tie_order();
		test_full_queue();
		test_random_traffic();

		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("sorted_priority_queue_unit_tb: done, clean");
		else
			$display("sorted_priority_queue_unit_tb: done, errors");
		$finish;
	end

endmodule
